### rtl/core/multilevel_feedback_queue_scheduler_defines.svh
// ---------------------------------------------------------------------------
// multilevel feedback queue scheduler assertion macros
// ---------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MLFQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MLFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mlfq_pkg.sv
// ---------------------------------------------------------------------------
// mlfq_pkg
// Shared constants, codes and control structs of the feedback queue scheduler
// ---------------------------------------------------------------------------
package mlfq_pkg;

    localparam int MAX_PROCS  = 128;
    localparam int TIME_BITS  = 24;
    localparam int NUM_LEVELS = 3;

    localparam int PIDX_W  = $clog2(MAX_PROCS);
    localparam int PCNT_W  = $clog2(MAX_PROCS + 1);
    localparam int QDEPTH  = NUM_LEVELS * MAX_PROCS;
    localparam int QADDR_W = $clog2(QDEPTH);
    localparam int DATA_W  = 16;
    localparam int LVL_W   = 2;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 2;
    localparam int OIDX_W  = 7;
    localparam int OTIME_W = 24;
    localparam int CFG_IDX_W = 2;

    // input commands
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

    // result event kinds
    localparam logic [KIND_W-1:0] EV_IDLE     = 2'd0;
    localparam logic [KIND_W-1:0] EV_DISPATCH = 2'd1;
    localparam logic [KIND_W-1:0] EV_DONE     = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST    = 2'd2;

    localparam logic [DATA_W-1:0] RST_QUANTUM0 = 16'd10;
    localparam logic [DATA_W-1:0] RST_QUANTUM1 = 16'd20;
    localparam logic [DATA_W-1:0] RST_BOOST    = 16'd100;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic load;
        logic mod_start;
        logic mod_step;
        logic boost_reset;
        logic scan_start;
        logic scan_boost;
        logic scan_arrival;
        logic pick;
        logic fetch;
        logic exec;
        logic set_idle;
        logic set_done;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic all_done;
        logic boost_enable;
        logic mod_done;
        logic mod_zero;
        logic scan_done;
        logic any_queued;
        logic out_busy;
    } dp_status_t;

endpackage

### rtl/core/mlfq_if.sv
// ---------------------------------------------------------------------------
// mlfq channel interfaces
// Valid/ready channels for commands, results and register writes
// ---------------------------------------------------------------------------
interface mlfq_in_if;
    logic                              valid;
    logic                              ready;
    logic [mlfq_pkg::CMD_W-1:0]        command;
    logic [mlfq_pkg::DATA_W-1:0]       arrive_at;
    logic [mlfq_pkg::DATA_W-1:0]       burst_len;

    modport source (output valid, command, arrive_at, burst_len, input ready);
    modport sink (input valid, command, arrive_at, burst_len, output ready);
endinterface

interface mlfq_out_if;
    logic                              valid;
    logic                              ready;
    logic [mlfq_pkg::KIND_W-1:0]       event_kind;
    logic [mlfq_pkg::OIDX_W-1:0]       proc_index;
    logic [mlfq_pkg::OTIME_W-1:0]      slice_start;
    logic [mlfq_pkg::DATA_W-1:0]       run_length;
    logic [mlfq_pkg::LVL_W-1:0]        queue_level;
    logic                              first_run;
    logic                              finished;
    logic [mlfq_pkg::OTIME_W-1:0]      time_after;

    modport source (output valid, event_kind, proc_index, slice_start, run_length,
                    queue_level, first_run, finished, time_after, input ready);
    modport sink (input valid, event_kind, proc_index, slice_start, run_length,
                  queue_level, first_run, finished, time_after, output ready);
endinterface

interface mlfq_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mlfq_pkg::CFG_IDX_W-1:0]    index;
    logic [mlfq_pkg::DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/mlfq_ram.sv
// ---------------------------------------------------------------------------
// mlfq_ram
// Generic single-write, single-read RAM with registered read data
// ---------------------------------------------------------------------------
module mlfq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/mlfq_ctrl.sv
// ---------------------------------------------------------------------------
// mlfq_ctrl
// Round sequencer: modulo check, boost and arrival scans, dispatch, result
// ---------------------------------------------------------------------------
module mlfq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [mlfq_pkg::CMD_W-1:0]  in_command,
    output logic                        in_ready,
    input  mlfq_pkg::dp_status_t        status,
    output mlfq_pkg::dp_cmd_t           cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOD,
        ST_BSCAN,
        ST_ASCAN,
        ST_PICK,
        ST_FETCH,
        ST_EXEC,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid & in_ready;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.clear = accept & (in_command == mlfq_pkg::CMD_CLEAR);
                cmd.load  = accept & (in_command == mlfq_pkg::CMD_LOAD);
                if (accept && in_command == mlfq_pkg::CMD_RUN)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                priority if (status.all_done)
                begin
                    cmd.set_done = 1'b1;
                    state_next   = ST_EMIT;
                end
                else if (status.boost_enable)
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_ASCAN;
                end
            end
            ST_MOD:
            begin
                if (!status.mod_done)
                begin
                    cmd.mod_step = 1'b1;
                end
                else
                begin
                    cmd.scan_start  = 1'b1;
                    cmd.boost_reset = status.mod_zero;
                    state_next      = status.mod_zero ? ST_BSCAN : ST_ASCAN;
                end
            end
            ST_BSCAN:
            begin
                if (status.scan_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_ASCAN;
                end
                else
                begin
                    cmd.scan_boost = 1'b1;
                end
            end
            ST_ASCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    cmd.scan_arrival = 1'b1;
                end
            end
            ST_PICK:
            begin
                if (status.any_queued)
                begin
                    cmd.pick   = 1'b1;
                    state_next = ST_FETCH;
                end
                else
                begin
                    cmd.set_idle = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/mlfq_datapath.sv
// ---------------------------------------------------------------------------
// mlfq_datapath
// Process stores, level queues, remainder unit, counters and result register
// ---------------------------------------------------------------------------
module mlfq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mlfq_pkg::dp_cmd_t             cmd,
    output mlfq_pkg::dp_status_t          status,
    input  logic                          cfg_we,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlfq_pkg::DATA_W-1:0]   cfg_data,
    input  logic [mlfq_pkg::DATA_W-1:0]   arrive_at,
    input  logic [mlfq_pkg::DATA_W-1:0]   burst_len,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mlfq_pkg::KIND_W-1:0]   event_kind,
    output logic [mlfq_pkg::OIDX_W-1:0]   proc_index,
    output logic [mlfq_pkg::OTIME_W-1:0]  slice_start,
    output logic [mlfq_pkg::DATA_W-1:0]   run_length,
    output logic [mlfq_pkg::LVL_W-1:0]    queue_level,
    output logic                          first_run,
    output logic                          finished,
    output logic [mlfq_pkg::OTIME_W-1:0]  time_after
);

    localparam int MAXP = mlfq_pkg::MAX_PROCS;
    localparam int PW   = mlfq_pkg::PIDX_W;
    localparam int CW   = mlfq_pkg::PCNT_W;
    localparam int TW   = mlfq_pkg::TIME_BITS;
    localparam int DW   = mlfq_pkg::DATA_W;
    localparam int LW   = mlfq_pkg::LVL_W;
    localparam int QW   = mlfq_pkg::QADDR_W;
    localparam int NL   = mlfq_pkg::NUM_LEVELS;
    localparam int MCW  = $clog2(TW + 1);

    // configuration registers
    logic [DW-1:0] quantum0_reg;
    logic [DW-1:0] quantum1_reg;
    logic [DW-1:0] boost_reg;

    // control state
    logic [CW-1:0]   pcount_reg;
    logic [CW-1:0]   dcount_reg;
    logic [TW-1:0]   clock_reg;
    logic [MAXP-1:0] started_reg;
    logic [MAXP-1:0] arrived_reg;
    logic [PW-1:0]   head_reg [NL];
    logic [CW-1:0]   qcount_reg [NL];
    logic [CW-1:0]   scan_idx_reg;
    logic            pend_valid_reg;
    logic [PW-1:0]   pend_idx_reg;
    logic [DW:0]     mod_rem_reg;
    logic [TW-1:0]   mod_shift_reg;
    logic [MCW-1:0]  mod_cnt_reg;
    logic            out_valid_reg;

    // payload registers
    logic [LW-1:0]   lvl_reg;
    logic [PW-1:0]   idx_reg;
    logic [mlfq_pkg::KIND_W-1:0] res_kind_reg;
    logic [PW-1:0]   res_idx_reg;
    logic [TW-1:0]   res_start_reg;
    logic [DW-1:0]   res_len_reg;
    logic [LW-1:0]   res_lvl_reg;
    logic            res_first_reg;
    logic            res_fin_reg;
    logic [mlfq_pkg::KIND_W-1:0] out_kind_reg;
    logic [PW-1:0]   out_idx_reg;
    logic [TW-1:0]   out_start_reg;
    logic [DW-1:0]   out_len_reg;
    logic [LW-1:0]   out_lvl_reg;
    logic            out_first_reg;
    logic            out_fin_reg;
    logic [TW-1:0]   out_after_reg;

    // memory ports
    logic [DW-1:0]   arr_rdata;
    logic [DW-1:0]   rem_rdata;
    logic [PW-1:0]   q_rdata;
    logic            load_ok;
    logic            rem_we;
    logic [PW-1:0]   rem_waddr;
    logic [DW-1:0]   rem_wdata;
    logic [PW-1:0]   rem_raddr;
    logic            q_we;
    logic [QW-1:0]   q_waddr;
    logic [QW-1:0]   q_raddr;

    // scan, dispatch and push signals
    logic            scanning;
    logic            scan_issue;
    logic            scan_push;
    logic [DW-1:0]   quantum;
    logic [DW-1:0]   run;
    logic [DW-1:0]   new_rem;
    logic            exec_push;
    logic            push;
    logic [LW-1:0]   push_lvl;
    logic [CW:0]     push_sum;
    logic [PW-1:0]   push_pos;
    logic [LW-1:0]   pick_lvl;
    logic [PW-1:0]   pick_head_next;
    logic [DW:0]     mod_shifted;
    logic [DW:0]     mod_rem_next;

    // process stores and level queues
    mlfq_ram #(.WIDTH(DW), .DEPTH(MAXP)) u_arr_ram (
        .clk   (clk),
        .we    (load_ok),
        .waddr (pcount_reg[PW-1:0]),
        .wdata (arrive_at),
        .raddr (scan_idx_reg[PW-1:0]),
        .rdata (arr_rdata)
    );

    mlfq_ram #(.WIDTH(DW), .DEPTH(MAXP)) u_rem_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .raddr (rem_raddr),
        .rdata (rem_rdata)
    );

    mlfq_ram #(.WIDTH(PW), .DEPTH(mlfq_pkg::QDEPTH)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (cmd.exec ? idx_reg : pend_idx_reg),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // store write and read addressing
    assign load_ok   = cmd.load & (pcount_reg < CW'(MAXP));
    assign rem_we    = load_ok | cmd.exec;
    assign rem_waddr = cmd.exec ? idx_reg : pcount_reg[PW-1:0];
    assign rem_wdata = cmd.exec ? new_rem : burst_len;
    assign rem_raddr = cmd.fetch ? q_rdata : scan_idx_reg[PW-1:0];

    // pipelined scan over the loaded processes
    assign scanning   = cmd.scan_boost | cmd.scan_arrival;
    assign scan_issue = scanning & (scan_idx_reg < pcount_reg);
    assign scan_push  = pend_valid_reg &
                        ((cmd.scan_boost & arrived_reg[pend_idx_reg] & (rem_rdata != '0)) |
                         (cmd.scan_arrival & ~arrived_reg[pend_idx_reg] &
                          (TW'(arr_rdata) <= clock_reg)));

    // slice length and remainder of the dispatched process
    always_comb
    begin
        unique case (lvl_reg)
            2'd0:    quantum = quantum0_reg;
            2'd1:    quantum = quantum1_reg;
            default: quantum = rem_rdata;
        endcase
    end

    assign run       = (rem_rdata < quantum) ? rem_rdata : quantum;
    assign new_rem   = rem_rdata - run;
    assign exec_push = cmd.exec & (new_rem != '0);

    // queue tail for a push
    assign push     = scan_push | exec_push;
    assign push_lvl = scan_push ? LW'(0) : ((lvl_reg == LW'(0)) ? LW'(1) : LW'(2));
    assign push_sum = (CW + 1)'(head_reg[push_lvl]) + (CW + 1)'(qcount_reg[push_lvl]);
    assign push_pos = (push_sum >= (CW + 1)'(MAXP)) ? PW'(push_sum - (CW + 1)'(MAXP))
                                                    : PW'(push_sum);
    assign q_we     = push;
    assign q_waddr  = QW'(push_lvl) * QW'(MAXP) + QW'(push_pos);

    // highest non-empty level
    always_comb
    begin
        priority if (qcount_reg[0] != '0)
        begin
            pick_lvl = LW'(0);
        end
        else if (qcount_reg[1] != '0)
        begin
            pick_lvl = LW'(1);
        end
        else
        begin
            pick_lvl = LW'(2);
        end
    end

    assign pick_head_next = (head_reg[pick_lvl] == PW'(MAXP - 1)) ? '0
                                                                   : head_reg[pick_lvl] + 1'b1;
    assign q_raddr        = QW'(pick_lvl) * QW'(MAXP) + QW'(head_reg[pick_lvl]);

    // restoring remainder step, one clock bit per cycle
    assign mod_shifted  = {mod_rem_reg[DW-1:0], mod_shift_reg[TW-1]};
    assign mod_rem_next = (mod_shifted >= (DW + 1)'(boost_reg))
                          ? mod_shifted - (DW + 1)'(boost_reg) : mod_shifted;

    // status to the controller
    assign status.all_done     = (dcount_reg >= pcount_reg);
    assign status.boost_enable = (clock_reg != '0) & (boost_reg != '0);
    assign status.mod_done     = (mod_cnt_reg == '0);
    assign status.mod_zero     = (mod_rem_reg == '0);
    assign status.scan_done    = ~pend_valid_reg & (scan_idx_reg >= pcount_reg);
    assign status.any_queued   = (qcount_reg[0] != '0) | (qcount_reg[1] != '0) |
                                 (qcount_reg[2] != '0);
    assign status.out_busy     = out_valid_reg & ~out_ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum0_reg   <= mlfq_pkg::RST_QUANTUM0;
            quantum1_reg   <= mlfq_pkg::RST_QUANTUM1;
            boost_reg      <= mlfq_pkg::RST_BOOST;
            pcount_reg     <= '0;
            dcount_reg     <= '0;
            clock_reg      <= '0;
            started_reg    <= '0;
            arrived_reg    <= '0;
            head_reg       <= '{default: '0};
            qcount_reg     <= '{default: '0};
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            mod_rem_reg    <= '0;
            mod_shift_reg  <= '0;
            mod_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mlfq_pkg::REG_QUANTUM0: quantum0_reg <= cfg_data;
                    mlfq_pkg::REG_QUANTUM1: quantum1_reg <= cfg_data;
                    mlfq_pkg::REG_BOOST:    boost_reg    <= cfg_data;
                    default: ;
                endcase
            end

            // clear and load
            if (cmd.clear)
            begin
                pcount_reg  <= '0;
                dcount_reg  <= '0;
                clock_reg   <= '0;
                started_reg <= '0;
                arrived_reg <= '0;
                head_reg    <= '{default: '0};
                qcount_reg  <= '{default: '0};
            end
            if (load_ok)
            begin
                pcount_reg                       <= pcount_reg + 1'b1;
                started_reg[pcount_reg[PW-1:0]]  <= 1'b0;
                arrived_reg[pcount_reg[PW-1:0]]  <= 1'b0;
            end

            // boost period remainder
            if (cmd.mod_start)
            begin
                mod_rem_reg   <= '0;
                mod_shift_reg <= clock_reg;
                mod_cnt_reg   <= MCW'(TW);
            end
            if (cmd.mod_step)
            begin
                mod_rem_reg   <= mod_rem_next;
                mod_shift_reg <= {mod_shift_reg[TW-2:0], 1'b0};
                mod_cnt_reg   <= mod_cnt_reg - 1'b1;
            end

            // boost empties all levels
            if (cmd.boost_reset)
            begin
                head_reg   <= '{default: '0};
                qcount_reg <= '{default: '0};
            end

            // scan counter and pending stage
            if (cmd.scan_start)
            begin
                scan_idx_reg   <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (scanning)
            begin
                pend_valid_reg <= scan_issue;
                if (scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    pend_idx_reg <= scan_idx_reg[PW-1:0];
                end
            end
            if (scan_push && cmd.scan_arrival)
            begin
                arrived_reg[pend_idx_reg] <= 1'b1;
            end

            // queue push and pop
            if (push)
            begin
                qcount_reg[push_lvl] <= qcount_reg[push_lvl] + 1'b1;
            end
            if (cmd.pick)
            begin
                head_reg[pick_lvl]   <= pick_head_next;
                qcount_reg[pick_lvl] <= qcount_reg[pick_lvl] - 1'b1;
            end

            // dispatch and idle tick advance the clock
            if (cmd.exec)
            begin
                started_reg[idx_reg] <= 1'b1;
                clock_reg            <= clock_reg + TW'(run);
                if (new_rem == '0)
                begin
                    dcount_reg <= dcount_reg + 1'b1;
                end
            end
            if (cmd.set_idle)
            begin
                clock_reg <= clock_reg + 1'b1;
            end

            // output register
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // round payload and result transfer register
    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            lvl_reg <= pick_lvl;
        end
        if (cmd.fetch)
        begin
            idx_reg <= q_rdata;
        end
        if (cmd.exec)
        begin
            res_kind_reg  <= mlfq_pkg::EV_DISPATCH;
            res_idx_reg   <= idx_reg;
            res_start_reg <= clock_reg;
            res_len_reg   <= run;
            res_lvl_reg   <= lvl_reg;
            res_first_reg <= ~started_reg[idx_reg];
            res_fin_reg   <= (new_rem == '0);
        end
        if (cmd.set_idle || cmd.set_done)
        begin
            res_kind_reg  <= cmd.set_idle ? mlfq_pkg::EV_IDLE : mlfq_pkg::EV_DONE;
            res_idx_reg   <= '0;
            res_start_reg <= clock_reg;
            res_len_reg   <= cmd.set_idle ? DW'(1) : DW'(0);
            res_lvl_reg   <= '0;
            res_first_reg <= 1'b0;
            res_fin_reg   <= 1'b0;
        end
        if (cmd.out_load)
        begin
            out_kind_reg  <= res_kind_reg;
            out_idx_reg   <= res_idx_reg;
            out_start_reg <= res_start_reg;
            out_len_reg   <= res_len_reg;
            out_lvl_reg   <= res_lvl_reg;
            out_first_reg <= res_first_reg;
            out_fin_reg   <= res_fin_reg;
            out_after_reg <= clock_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = out_kind_reg;
    assign proc_index  = mlfq_pkg::OIDX_W'(out_idx_reg);
    assign slice_start = mlfq_pkg::OTIME_W'(out_start_reg);
    assign run_length  = out_len_reg;
    assign queue_level = out_lvl_reg;
    assign first_run   = out_first_reg;
    assign finished    = out_fin_reg;
    assign time_after  = mlfq_pkg::OTIME_W'(out_after_reg);

endmodule

### rtl/core/multilevel_feedback_queue_scheduler.sv
// ---------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Three-level feedback queue scheduler with boost, one round per run command
// ---------------------------------------------------------------------------
// Clear and load commands produce no result. A run command works out the
// boost period remainder whenever the clock and the boost interval are
// nonzero, and rescans the processes when a boost fires; a run with every
// process already finished only reports completion. A result may wait for
// a full output register. Run time is set by the bit-serial remainder unit
// and by the single read port of the process stores, which the arrival and
// boost scans walk one process per cycle. A result waits in an output
// register; the next command is taken once the result is in that register.
// No memory needs a clearing pass after reset.
module multilevel_feedback_queue_scheduler (
    input  logic    clk,
    input  logic    rst_n,
    mlfq_in_if.sink     item,
    mlfq_out_if.source  result,
    mlfq_cfg_if.sink    cfg
);

    mlfq_pkg::dp_cmd_t    dp_cmd;
    mlfq_pkg::dp_status_t dp_status;

    // register writes are always taken
    assign cfg.ready = 1'b1;

    // round sequencer
    mlfq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item.valid),
        .in_command (item.command),
        .in_ready   (item.ready),
        .status     (dp_status),
        .cmd        (dp_cmd)
    );

    // stores, queues and result register
    mlfq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .cfg_we       (cfg.valid & cfg.ready),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .arrive_at    (item.arrive_at),
        .burst_len    (item.burst_len),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .event_kind   (result.event_kind),
        .proc_index   (result.proc_index),
        .slice_start  (result.slice_start),
        .run_length   (result.run_length),
        .queue_level  (result.queue_level),
        .first_run    (result.first_run),
        .finished     (result.finished),
        .time_after   (result.time_after)
    );

endmodule

### rtl/core/mlfq_checker.sv
// ---------------------------------------------------------------------------
// mlfq_checker
// Port-level checks on the result channel of the scheduler
// ---------------------------------------------------------------------------
`include "multilevel_feedback_queue_scheduler_defines.svh"

module mlfq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mlfq_pkg::KIND_W-1:0]   event_kind,
    input logic [mlfq_pkg::OTIME_W-1:0]  slice_start,
    input logic [mlfq_pkg::DATA_W-1:0]   run_length,
    input logic [mlfq_pkg::OTIME_W-1:0]  time_after
);

    // a stalled result holds
    `MLFQ_ASSERT_NEXT(a_result_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(event_kind) && $stable(time_after), "result changed while stalled")

    // idle tick advances the clock by one
    `MLFQ_ASSERT_IMPLY(a_idle_tick, clk, rst_n, out_valid && event_kind == mlfq_pkg::EV_IDLE, run_length == 16'd1 && time_after == 24'(slice_start + 24'd1), "idle tick timing wrong")

    // dispatch ends the round at slice end
    `MLFQ_ASSERT_IMPLY(a_slice_end, clk, rst_n, out_valid && event_kind == mlfq_pkg::EV_DISPATCH, time_after == 24'(slice_start + 24'(run_length)), "slice end mismatch")

    // completion report leaves the clock alone
    `MLFQ_ASSERT_IMPLY(a_done_report, clk, rst_n, out_valid && event_kind == mlfq_pkg::EV_DONE, time_after == slice_start && run_length == 16'd0, "completion report wrong")

endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_mlfq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .event_kind  (result.event_kind),
    .slice_start (result.slice_start),
    .run_length  (result.run_length),
    .time_after  (result.time_after)
);
